>>> design/ivt_pkg.sv
// Package for the integer variable table: sizes, command and status codes,
// state encoding, the result bundle and the name normalization function.
// Used by integer_variable_table_top, ivt_ctrl and the testbench; depends on nothing.
package ivt_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned NAME_CHARS  = 8;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ENT_W = KEY_W + VAL_W;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    CmdSet   = 2'd0,
    CmdGet   = 2'd1,
    CmdClear = 2'd2,
    CmdNop   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StsOk       = 2'd0,
    StsFull     = 2'd1,
    StsNotFound = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StResp
  } state_e;

  typedef struct packed {
    status_e           status;
    logic [VAL_W-1:0]  value;
  } res_t;

  // Keeps the low NAME_CHARS bytes up to the first zero byte.
  function automatic logic [KEY_W-1:0] normalize_name(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] key;
    logic             stop;
    key  = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i < NAME_CHARS) begin
        if (raw[8*i +: 8] == 8'h00) begin
          stop = 1'b1;
        end
        if (!stop) begin
          key[8*i +: 8] = raw[8*i +: 8];
        end
      end
    end
    return key;
  endfunction

endpackage

>>> design/integer_variable_table_top.sv
// Clear, no-op and set or get on an empty table go straight to the response; set and get
// on a non-empty table first scan the entries in order (at most 32), one per RAM read.
// The sequencer handles one command at a time.
// The output register lets a new command start while the previous result waits.
// Reset empties the table and the output register; entry contents are not cleared.
// Top level of the integer variable table; uses ivt_pkg, ivt_ram and ivt_ctrl.
module integer_variable_table_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [63:0]         var_name_i,
  input  logic signed [31:0]  new_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic signed [31:0]  read_value_o
);

  logic                      res_valid;
  logic                      res_ready;
  ivt_pkg::res_t             res;
  logic                      ram_we;
  logic [ivt_pkg::IDX_W-1:0] ram_waddr;
  logic [ivt_pkg::ENT_W-1:0] ram_wdata;
  logic [ivt_pkg::IDX_W-1:0] ram_raddr;
  logic [ivt_pkg::ENT_W-1:0] ram_rdata;

  logic                      out_valid_q, out_valid_d;
  ivt_pkg::res_t             out_q;

  ivt_ram #(
    .DEPTH (ivt_pkg::TABLE_DEPTH),
    .WIDTH (ivt_pkg::ENT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ivt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .var_name_i  (var_name_i),
    .new_value_i (new_value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign read_value_o = out_q.value;

endmodule

>>> design/ivt_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Holds the table entries; depends on nothing.
module ivt_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 96,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/ivt_ctrl.sv
// Command sequencer of the integer variable table: accepts a command, scans the
// entry RAM one entry per cycle, writes back and hands a result on. Uses ivt_pkg.
module ivt_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 command_i,
  input  logic [ivt_pkg::KEY_W-1:0]  var_name_i,
  input  logic [ivt_pkg::VAL_W-1:0]  new_value_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output ivt_pkg::res_t              res_o,
  output logic                       ram_we_o,
  output logic [ivt_pkg::IDX_W-1:0]  ram_waddr_o,
  output logic [ivt_pkg::ENT_W-1:0]  ram_wdata_o,
  output logic [ivt_pkg::IDX_W-1:0]  ram_raddr_o,
  input  logic [ivt_pkg::ENT_W-1:0]  ram_rdata_i
);

  ivt_pkg::state_e           state_q, state_d;
  logic [ivt_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [ivt_pkg::CNT_W-1:0] used_q, used_d;
  ivt_pkg::cmd_e             cmd_q, cmd_d;
  logic [ivt_pkg::KEY_W-1:0] key_q, key_d;
  logic [ivt_pkg::VAL_W-1:0] val_q, val_d;
  ivt_pkg::res_t             res_q, res_d;

  logic                      accept;
  logic                      hit;
  logic                      last;
  logic                      full;
  logic [ivt_pkg::KEY_W-1:0] rd_key;
  logic [ivt_pkg::VAL_W-1:0] rd_val;

  assign accept = in_valid_i && (state_q == ivt_pkg::StIdle);
  assign rd_key = ram_rdata_i[ivt_pkg::ENT_W-1 -: ivt_pkg::KEY_W];
  assign rd_val = ram_rdata_i[ivt_pkg::VAL_W-1:0];
  assign hit    = (rd_key == key_q);
  assign last   = ((ivt_pkg::CNT_W'(idx_q) + ivt_pkg::CNT_W'(1)) == used_q);
  assign full   = (used_q == ivt_pkg::CNT_W'(ivt_pkg::TABLE_DEPTH));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ivt_pkg::StIdle: begin
        if (accept) begin
          if (((ivt_pkg::cmd_e'(command_i) == ivt_pkg::CmdSet) ||
               (ivt_pkg::cmd_e'(command_i) == ivt_pkg::CmdGet)) &&
              (used_q != '0)) begin
            state_d = ivt_pkg::StScan;
          end else begin
            state_d = ivt_pkg::StResp;
          end
        end
      end
      ivt_pkg::StScan: begin
        if (hit || last) begin
          state_d = ivt_pkg::StResp;
        end
      end
      ivt_pkg::StResp: begin
        if (res_ready_i) begin
          state_d = ivt_pkg::StIdle;
        end
      end
      default: state_d = ivt_pkg::StIdle;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    used_d      = used_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    val_d       = val_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = used_q[ivt_pkg::IDX_W-1:0];
    ram_wdata_o = {key_q, val_q};
    ram_raddr_o = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ivt_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (accept) begin
          cmd_d = ivt_pkg::cmd_e'(command_i);
          key_d = ivt_pkg::normalize_name(var_name_i);
          val_d = new_value_i;
          idx_d = '0;
          res_d = '{status: ivt_pkg::StsOk, value: '0};
          unique case (ivt_pkg::cmd_e'(command_i))
            ivt_pkg::CmdSet: begin
              if (used_q == '0) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = '0;
                ram_wdata_o = {key_d, new_value_i};
                used_d      = ivt_pkg::CNT_W'(1);
              end
            end
            ivt_pkg::CmdGet: begin
              if (used_q == '0) begin
                res_d.status = ivt_pkg::StsNotFound;
              end
            end
            ivt_pkg::CmdClear: begin
              used_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ivt_pkg::StScan: begin
        ram_raddr_o = idx_q + ivt_pkg::IDX_W'(1);
        if (hit) begin
          if (cmd_q == ivt_pkg::CmdSet) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = idx_q;
          end else begin
            res_d.value = rd_val;
          end
        end else if (last) begin
          if (cmd_q == ivt_pkg::CmdSet) begin
            if (full) begin
              res_d.status = ivt_pkg::StsFull;
            end else begin
              ram_we_o = 1'b1;
              used_d   = used_q + ivt_pkg::CNT_W'(1);
            end
          end else begin
            res_d.status = ivt_pkg::StsNotFound;
          end
        end else begin
          idx_d = idx_q + ivt_pkg::IDX_W'(1);
        end
      end
      ivt_pkg::StResp: begin
        res_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ivt_pkg::StIdle;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cmd_q <= cmd_d;
    key_q <= key_d;
    val_q <= val_d;
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Testbench for integer_variable_table_top: directed and random set, get, clear and no-op
// transfers checked against a predictor of the table. Depends on ivt_pkg and the RTL only.
module tb;
  import ivt_pkg::*;

  localparam int NAME_POOL = 40;

  typedef struct {
    status_e     status;
    logic [31:0] value;
  } answer_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         command_i;
  logic [63:0]        var_name_i;
  logic signed [31:0] new_value_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] read_value_o;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  int mismatch_count = 0;

  logic [63:0] tbl_keys [TABLE_DEPTH];
  logic [31:0] tbl_vals [TABLE_DEPTH];
  int          tbl_used = 0;
  answer_t     pending_answers [$];
  logic [63:0] name_pool [NAME_POOL];

  integer_variable_table_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .var_name_i  (var_name_i),
    .new_value_i (new_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .read_value_o(read_value_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic [63:0] canon_name(input logic [63:0] raw);
    logic [63:0] key;
    key = '0;
    for (int n = 0; n < NAME_CHARS; n++) begin
      if (raw[8*n +: 8] == 8'h00) break;
      key[8*n +: 8] = raw[8*n +: 8];
    end
    return key;
  endfunction

  function automatic answer_t apply_command(input cmd_e cmd, input logic [63:0] name,
                                            input logic [31:0] val);
    answer_t     ans;
    logic [63:0] key;
    int          hit;
    ans.status = StsOk;
    ans.value  = '0;
    key = canon_name(name);
    hit = -1;
    for (int i = 0; i < tbl_used; i++) begin
      if (hit < 0 && tbl_keys[i] == key) hit = i;
    end
    case (cmd)
      CmdSet: begin
        if (hit >= 0) begin
          tbl_vals[hit] = val;
        end else if (tbl_used < TABLE_DEPTH) begin
          tbl_keys[tbl_used] = key;
          tbl_vals[tbl_used] = val;
          tbl_used++;
        end else begin
          ans.status = StsFull;
        end
      end
      CmdGet: begin
        if (hit >= 0) begin
          ans.value = tbl_vals[hit];
        end else begin
          ans.status = StsNotFound;
        end
      end
      CmdClear: begin
        tbl_used = 0;
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  // May fill the bytes after the terminating zero with junk that must be ignored.
  function automatic logic [63:0] dress_name(input logic [63:0] key);
    logic [63:0] raw;
    int          len;
    raw = key;
    len = 8;
    for (int n = 7; n >= 0; n--) begin
      if (key[8*n +: 8] == 8'h00) len = n;
    end
    if (len < 7 && $urandom_range(99) < 35) begin
      for (int b = len + 1; b < 8; b++) raw[8*b +: 8] = 8'($urandom);
    end
    return raw;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_command(input cmd_e cmd, input logic [63:0] name,
                               input logic [31:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    var_name_i  <= name;
    new_value_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_answers.push_back(apply_command(cmd, name, val));
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    answer_t ans;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        $error("result transfer with no command outstanding");
        mismatch_count++;
      end else begin
        ans = pending_answers.pop_front();
        if (status_o !== ans.status) begin
          $error("status: expected %0d, got %0d", ans.status, status_o);
          mismatch_count++;
        end
        if (read_value_o !== ans.value) begin
          $error("read_value: expected %h, got %h", ans.value, read_value_o);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_empty_table();
    issue_command(CmdGet, 64'h41, 32'h1234_5678);
    issue_command(CmdNop, 64'h41, 32'h1);
    issue_command(CmdClear, 64'h0, 32'h0);
  endtask

  task automatic test_value_and_name_extremes();
    issue_command(CmdSet, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
    issue_command(CmdGet, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    issue_command(CmdSet, 64'h0, 32'h8000_0000);
    issue_command(CmdGet, 64'h0, 32'hFFFF_FFFF);
    issue_command(CmdGet, 64'hFFFF_FFFF_FFFF_FF00, 32'h0);
    issue_command(CmdSet, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    issue_command(CmdGet, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
  endtask

  task automatic test_name_normalization();
    issue_command(CmdSet, 64'h0000_0000_0000_6261, 32'd5);
    issue_command(CmdGet, 64'hAAAA_0000_0000_6261, 32'h0);
    issue_command(CmdGet, 64'h0000_0000_0063_6261, 32'h0);
    issue_command(CmdSet, 64'hFF00_FFFF_FFFF_6261, 32'hDEAD_BEEF);
    issue_command(CmdGet, 64'h1200_FFFF_FFFF_6261, 32'h0);
  endtask

  task automatic test_clear();
    issue_command(CmdClear, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    issue_command(CmdGet, 64'h0000_0000_0000_6261, 32'h0);
    issue_command(CmdGet, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    issue_command(CmdSet, 64'h0000_0000_0000_6261, 32'h8000_0001);
    issue_command(CmdGet, 64'h0000_0000_0000_6261, 32'h0);
    issue_command(CmdNop, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Most episodes start with a clear of the table and draw mostly from a small name pool,
  // so that hits, misses and a full table all occur.
  task automatic test_random_traffic(input int n_items);
    int          sent;
    int          roll;
    int          pos;
    logic [63:0] nm;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        issue_command(CmdClear, {$urandom, $urandom}, $urandom);
        sent++;
      end
      repeat ($urandom_range(20, 110)) begin
        if (sent >= n_items) break;
        roll = $urandom_range(99);
        nm   = dress_name(name_pool[$urandom_range(NAME_POOL - 1)]);
        if (roll < 46) begin
          issue_command(CmdSet, nm, pick_value());
        end else if (roll < 84) begin
          issue_command(CmdGet, nm, $urandom);
        end else if (roll < 90) begin
          issue_command(roll[0] ? CmdSet : CmdGet, {$urandom, $urandom}, $urandom);
        end else if (roll < 95) begin
          issue_command(CmdNop, {$urandom, $urandom}, $urandom);
        end else if (roll < 97) begin
          issue_command(CmdClear, nm, $urandom);
        end else begin
          pos = $urandom_range(7);
          nm[8*pos +: 8] = 8'($urandom);
          issue_command(CmdGet, nm, $urandom);
        end
        sent++;
      end
    end
  endtask

  task automatic test_output_stall();
    hold_left = 300;
    for (int i = 0; i < 12; i++) begin
      if (i[0]) begin
        issue_command(CmdGet, name_pool[i], $urandom);
      end else begin
        issue_command(CmdSet, name_pool[i], pick_value());
      end
    end
  endtask

  initial begin
    int len;
    in_valid_i  = 1'b0;
    command_i   = CmdNop;
    var_name_i  = '0;
    new_value_i = '0;
    rst_ni      = 1'b0;
    name_pool[0] = '0;
    for (int i = 1; i < NAME_POOL; i++) begin
      name_pool[i] = '0;
      len = $urandom_range(1, 8);
      for (int b = 0; b < len; b++) name_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 18;
    rx_idle_pct = 79;
    test_empty_table();
    test_value_and_name_extremes();
    test_name_normalization();
    test_clear();
    test_random_traffic(320);

    tx_idle_pct = 79;
    rx_idle_pct = 18;
    test_random_traffic(320);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_output_stall();
    test_random_traffic(310);

    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
